// ===== design/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, register indexes and helpers for the escape-time pixel block.
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 16;
  localparam int FRAC_BITS  = 28;

  localparam int CW      = 32;                 // c and config word width
  localparam int Z_W     = 40;                 // z components
  localparam int MUL_W   = 33;                 // multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = CW + COORD_BITS + 2; // x_min + col*x_step, exact
  localparam int GRAY_W  = 8;
  localparam int DIV_W   = ITER_BITS + GRAY_W;

  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8;         // col, row packed to bytes
  localparam int OUT_W     = ((GRAY_W + ITER_BITS + 1 + 7) / 8) * 8; // gray, iterations, inside

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

  localparam logic [GRAY_W-1:0] GRAY_FULL = '1;

  // Clamp the exact coordinate sum into the signed CW-bit range.
  function automatic logic [CW-1:0] sat_coord(input logic [SUM_W-1:0] v);
    logic [SUM_W-CW:0] upper;
    upper = v[SUM_W-1:CW-1];
    if ((&upper) || !(|upper)) begin
      sat_coord = v[CW-1:0];
    end else if (v[SUM_W-1]) begin
      sat_coord = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/mep_gray_div.sv =====
// ----------------------------------------------------------------------------
// mep_gray_div
// Serial restoring divider: gray = floor(255 * iter / limit), iter < limit.
// ----------------------------------------------------------------------------
module mep_gray_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mep_pkg::ITER_BITS-1:0]  iter_i,
  input  logic [mep_pkg::ITER_BITS-1:0]  limit_i,
  output logic                           done_o,
  output logic [mep_pkg::GRAY_W-1:0]     gray_o
);
  import mep_pkg::*;

  logic [DIV_W-1:0]  rem_q, den_q;
  logic [GRAY_W-1:0] quot_q;
  logic [2:0]        cnt_q;
  logic              busy_q, done_q;
  logic [DIV_W:0]    diff;
  logic [DIV_W-1:0]  iter_ext;

  assign iter_ext = {{GRAY_W{1'b0}}, iter_i};
  assign diff     = {1'b0, rem_q} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 3'd0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, MSB first; quotient fits 8 bits as iter < limit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= (iter_ext << GRAY_W) - iter_ext;
      den_q  <= {1'b0, limit_i, {(GRAY_W-1){1'b0}}};
      cnt_q  <= 3'd7;
      quot_q <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[GRAY_W-2:0], ~diff[DIV_W]};
      if (!diff[DIV_W]) begin
        rem_q <= diff[DIV_W-1:0];
      end
      den_q <= den_q >> 1;
      cnt_q <= cnt_q - 3'd1;
    end
  end

  assign done_o = done_q;
  assign gray_o = quot_q;

endmodule

// ===== design/mandelbrot_escape_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time iteration for one pixel, with iteration count and gray level.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                   contents
//  s_axis    in   tvalid/tready               tdata: col[11:0], row[23:12]
//  m_axis    out  tvalid/tready               tdata: gray[7:0], iterations[23:8],
//                                                    inside_res[24]
//  cfg       in   cfg_we_i (no wait)          cfg_idx_i selects, cfg_wdata_i value
//
//  Per pixel: setup of c runs col*x_step and row*y_step through the multiplier,
//  each iteration runs three products through the one 33x33 multiplier plus a
//  check; then follow the gray division and the output load.
//  Pixels that hit the limit skip the division (gray fixed at full scale).
//  One pixel in flight; s_axis_tready is high only in idle. A finished
//  result sits in the output register, so the next pixel may be taken while
//  it waits; a further result waits in the sequencer until m_axis is free.
//  Reset: asynchronous, active low; config registers return to defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave: col[11:0], row[23:12]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mep_pkg::IN_W-1:0]        s_axis_tdata,
  // master: gray[7:0], iterations[23:8], inside_res[24], zero pad above
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mep_pkg::OUT_W-1:0]       m_axis_tdata,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mep_pkg::CW-1:0]          cfg_wdata_i
);
  import mep_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_CR = 4'd1;  // col * x_step
  localparam logic [3:0] ST_MUL_CI = 4'd2;  // cr done, row * y_step
  localparam logic [3:0] ST_SAT_CI = 4'd3;  // ci done, z cleared
  localparam logic [3:0] ST_CHECK  = 4'd4;  // limit and component > 2 test, zr*zr
  localparam logic [3:0] ST_SQ_I   = 4'd5;  // sr taken, zi*zi
  localparam logic [3:0] ST_CROSS  = 4'd6;  // si taken, |z|^2 test, 2zr*zi
  localparam logic [3:0] ST_UPD    = 4'd7;  // new z
  localparam logic [3:0] ST_DIV    = 4'd8;  // gray division
  localparam logic [3:0] ST_OUT    = 4'd9;  // wait for output register

  localparam logic signed [Z_W-1:0] TWO_Z  = Z_W'(64'sd1 <<< (FRAC_BITS + 1));
  localparam logic signed [Z_W-1:0] FOUR_Z = Z_W'(64'sd1 <<< (FRAC_BITS + 2));

  // configuration
  logic [CW-1:0]        x_min_q, x_step_q, y_min_q, y_step_q;
  logic [ITER_BITS-1:0] max_iter_q;

  // sequencer and datapath
  logic [3:0]               state_q, state_d;
  logic [COORD_BITS-1:0]    col_q, row_q;
  logic [ITER_BITS-1:0]     limit_q, it_q;
  logic [CW-1:0]            cr_q, ci_q;
  logic signed [Z_W-1:0]    zr_q, zi_q, sr_q, si_q;
  logic                     inside_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q, prod_shr;
  logic signed [Z_W-1:0]    prod_z, cr_z, ci_z;
  logic [SUM_W-1:0]         sum_x, sum_y;
  logic                     z_big, mag_big, div_start, div_done, out_load;
  logic [GRAY_W-1:0]        div_gray;

  // output register
  logic                     m_valid_q;
  logic [GRAY_W-1:0]        gray_q;
  logic [ITER_BITS-1:0]     iters_q;
  logic                     inside_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= 32'hD800_0000;   // -2.5
      x_step_q   <= 32'd734577;
      y_min_q    <= 32'hEC00_0000;   // -1.25
      y_step_q   <= 32'd933365;
      max_iter_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_MIN:    x_min_q    <= cfg_wdata_i;
        REG_X_STEP:   x_step_q   <= cfg_wdata_i;
        REG_Y_MIN:    y_min_q    <= cfg_wdata_i;
        REG_Y_STEP:   y_step_q   <= cfg_wdata_i;
        REG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, product registered every cycle
  always_comb begin
    case (state_q)
      ST_MUL_CR: begin
        mul_a = {{(MUL_W-COORD_BITS){1'b0}}, col_q};
        mul_b = {x_step_q[CW-1], x_step_q};
      end
      ST_MUL_CI: begin
        mul_a = {{(MUL_W-COORD_BITS){1'b0}}, row_q};
        mul_b = {y_step_q[CW-1], y_step_q};
      end
      ST_CHECK: begin
        mul_a = zr_q[MUL_W-1:0];
        mul_b = zr_q[MUL_W-1:0];
      end
      ST_SQ_I: begin
        mul_a = zi_q[MUL_W-1:0];
        mul_b = zi_q[MUL_W-1:0];
      end
      default: begin
        mul_a = {zr_q[MUL_W-2:0], 1'b0};   // 2*zr, |zr| <= 2 here
        mul_b = zi_q[MUL_W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // floor to FRAC_BITS fraction bits is an arithmetic shift
  assign prod_shr = prod_q >>> FRAC_BITS;
  assign prod_z   = prod_shr[Z_W-1:0];
  assign cr_z     = {{(Z_W-CW){cr_q[CW-1]}}, cr_q};
  assign ci_z     = {{(Z_W-CW){ci_q[CW-1]}}, ci_q};
  assign sum_x    = {{(SUM_W-CW){x_min_q[CW-1]}}, x_min_q} + prod_q[SUM_W-1:0];
  assign sum_y    = {{(SUM_W-CW){y_min_q[CW-1]}}, y_min_q} + prod_q[SUM_W-1:0];

  assign z_big   = (zr_q > TWO_Z) || (zr_q < -TWO_Z) || (zi_q > TWO_Z) || (zi_q < -TWO_Z);
  assign mag_big = (sr_q + prod_z) > FOUR_Z;
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_MUL_CR;
      ST_MUL_CR: state_d = ST_MUL_CI;
      ST_MUL_CI: state_d = ST_SAT_CI;
      ST_SAT_CI: state_d = ST_CHECK;
      ST_CHECK: begin
        if (it_q >= limit_q) begin
          state_d = ST_OUT;
        end else if (z_big) begin
          state_d   = ST_DIV;
          div_start = 1'b1;
        end else begin
          state_d = ST_SQ_I;
        end
      end
      ST_SQ_I: state_d = ST_CROSS;
      ST_CROSS: begin
        if (mag_big) begin
          state_d   = ST_DIV;
          div_start = 1'b1;
        end else begin
          state_d = ST_UPD;
        end
      end
      ST_UPD:  state_d = ST_CHECK;
      ST_DIV:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        col_q   <= s_axis_tdata[COORD_BITS-1:0];
        row_q   <= s_axis_tdata[COORD_BITS +: COORD_BITS];
        limit_q <= max_iter_q;
      end
      ST_MUL_CI: cr_q <= sat_coord(sum_x);
      ST_SAT_CI: begin
        ci_q <= sat_coord(sum_y);
        zr_q <= '0;
        zi_q <= '0;
        it_q <= '0;
      end
      ST_CHECK: inside_q <= (it_q >= limit_q);
      ST_SQ_I:  sr_q <= prod_z;
      ST_CROSS: si_q <= prod_z;
      ST_UPD: begin
        zr_q <= sr_q - si_q + cr_z;
        zi_q <= prod_z + ci_z;
        it_q <= it_q + 1'b1;
      end
      default: ;
    endcase
  end

  mep_gray_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .iter_i  (it_q),
    .limit_i (limit_q),
    .done_o  (div_done),
    .gray_o  (div_gray)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      gray_q       <= inside_q ? GRAY_FULL : div_gray;
      iters_q      <= it_q;
      inside_res_q <= inside_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_W-GRAY_W-ITER_BITS-1){1'b0}}, inside_res_q, iters_q, gray_q};

  // checks
  a_sq_operand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ_I) |-> (zr_q <= TWO_Z && zr_q >= -TWO_Z &&
                              zi_q <= TWO_Z && zi_q >= -TWO_Z))
    else $error("squaring operand out of range");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (it_q < limit_q))
    else $error("iteration past limit");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside division");

  a_inside_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) && inside_res_q |-> (gray_q == GRAY_FULL && iters_q == limit_q))
    else $error("inside pixel with wrong gray or count");

endmodule

// ===== tb/sv/mandelbrot_escape_pixel_test.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_test
// Self-checking bench for the escape-time pixel block. Pixels go in over the
// slave stream, and a local predictor in Q4.28 works out the count, the inside
// flag and the gray level for each accepted beat. Each master beat is checked
// against the oldest prediction. The run covers directed corners (saturated
// c, zero and full-scale limits, ignored register writes) and then phases of
// random views of the set.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mep_pkg::*;

  // The cycle limit covers the slowest legal run: 600 pixels at up to 300
  // iterations, plus one full-scale pixel (65535 iterations).
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int          IDLE_PCT    = 20;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [GRAY_W-1:0]    gray;
    logic [ITER_BITS-1:0] iterations;
    logic                 inside_res;
  } escape_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;    // col[11:0], row[23:12]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;          // gray[7:0], iterations[23:8],
                                               // inside_res[24]
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CW-1:0]        cfg_wdata_i = '0;

  // Local copy of the register file, as it stands after reset.
  logic signed [CW-1:0] x_min_q    = -32'sd671088640;
  logic signed [CW-1:0] x_step_q   = 32'sd734577;
  logic signed [CW-1:0] y_min_q    = -32'sd335544320;
  logic signed [CW-1:0] y_step_q   = 32'sd933365;
  logic [ITER_BITS-1:0] max_iter_q = 16'd1000;

  escape_res_t pixels_due[$];   // predictions waiting for their beat
  int          faults = 0;
  int unsigned cycles = 0;
  bit          quiet  = 1'b0;   // no idling on either side while set

  mandelbrot_escape_pixel u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp an exact coordinate sum into Q4.28, i.e. [-8, 8 - 2^-28].
  function automatic longint clamp_coord(input longint v);
    longint hi, lo;
    hi = (longint'(1) << (FRAC_BITS + 3)) - 1;
    lo = -(longint'(1) << (FRAC_BITS + 3));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic escape_res_t predict_escape(input coord_t col, input coord_t row);
    longint      cr, ci, zr, zi, sq_r, sq_i, next_i, two, four;
    int unsigned count, limit;
    escape_res_t res;
    limit = 32'(max_iter_q);
    cr    = clamp_coord(longint'(x_min_q) + longint'(col) * longint'(x_step_q));
    ci    = clamp_coord(longint'(y_min_q) + longint'(row) * longint'(y_step_q));
    two   = longint'(1) << (FRAC_BITS + 1);
    four  = longint'(1) << (FRAC_BITS + 2);
    zr    = 0;
    zi    = 0;
    count = 0;
    while (count < limit) begin
      // a component beyond 2 has escaped before squaring
      if (zr > two || zr < -two || zi > two || zi < -two) break;
      // operands stay below 2^30, so the products fit; >>> floors
      sq_r = (zr * zr) >>> FRAC_BITS;
      sq_i = (zi * zi) >>> FRAC_BITS;
      if (sq_r + sq_i > four) break;
      next_i = ((2 * zr * zi) >>> FRAC_BITS) + ci;
      zr     = sq_r - sq_i + cr;
      zi     = next_i;
      count++;
    end
    res.iterations = count[ITER_BITS-1:0];
    res.inside_res = (count >= limit);
    // limit reached (zero limit too): full scale, no division
    res.gray = res.inside_res ? GRAY_FULL : GRAY_W'((255 * count) / limit);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Master side: random back-pressure and result checking
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    escape_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixels_due.size() == 0) begin
        $error("result beat with no pixel pending: tdata %h", m_axis_tdata);
        faults++;
      end else begin
        want = pixels_due.pop_front();
        check_field("gray", 32'(want.gray), 32'(m_axis_tdata[7:0]));
        check_field("iterations", 32'(want.iterations), 32'(m_axis_tdata[23:8]));
        check_field("inside_res", 32'(want.inside_res), 32'(m_axis_tdata[24]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("mandelbrot_escape_pixel_test: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Slave side and register port
  // --------------------------------------------------------------------------

  // Every task below is entered just after a rising edge. tvalid is left high
  // after a beat so back-to-back pixels keep it up; drain_pixels lowers it.
  task automatic send_pixel(input coord_t col, input coord_t row);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_due.push_back(predict_escape(col, row));
  endtask

  task automatic drain_pixels;
    s_axis_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    // one pixel in flight at most, so a short settle is enough
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_X_MIN:    x_min_q    = value;
      REG_X_STEP:   x_step_q   = value;
      REG_Y_MIN:    y_min_q    = value;
      REG_Y_STEP:   y_step_q   = value;
      REG_MAX_ITER: max_iter_q = value[ITER_BITS-1:0];
      default: ;  // unmapped index, nothing changes
    endcase
  endtask

  task automatic write_view(input logic [CW-1:0] x0, input logic [CW-1:0] dx,
                            input logic [CW-1:0] y0, input logic [CW-1:0] dy,
                            input logic [CW-1:0] limit);
    write_reg(REG_X_MIN, x0);
    write_reg(REG_X_STEP, dx);
    write_reg(REG_Y_MIN, y0);
    write_reg(REG_Y_STEP, dy);
    write_reg(REG_MAX_ITER, limit);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset view (-2.5..+, -1.25..+), limit 1000. The far corner saturates c;
  // (822, 360) sits in the main cardioid and runs to the limit.
  task automatic test_reset_view;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'd822, 12'd360);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain_pixels();
  endtask

  // Limit of zero via a wide write: upper half set, low 16 bits clear.
  task automatic test_zero_limit;
    write_reg(REG_MAX_ITER, 32'hFFFF_0000);
    send_pixel(12'd822, 12'd360);
    send_pixel(12'd0, 12'd0);
    drain_pixels();
  endtask

  // Writes to unmapped indexes must leave the view alone; limit of one.
  task automatic test_unmapped_and_min_limit;
    for (int i = REG_MAX_ITER + 1; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), $urandom);
    end
    write_reg(REG_MAX_ITER, 32'd1);
    send_pixel(12'd822, 12'd360);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd1, 12'd2);
    drain_pixels();
  endtask

  // Register extremes with the full-scale limit. (1, 1) lands next to the
  // origin and runs all 65535 iterations; the rest escape at once or
  // saturate c in either direction.
  task automatic test_extreme_views;
    write_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0000_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    drain_pixels();
    write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    drain_pixels();
  endtask

  // Phases of random views. Most frame the interesting part of the plane
  // with fine steps so pixels mix escapes and limit hits; one in eight takes
  // arbitrary register words. Limits stay small to keep the run short.
  task automatic test_random_views;
    logic [CW-1:0] x0, y0, dx, dy, limit;
    for (int phase = 0; phase < 30; phase++) begin
      quiet = (phase >= 12 && phase < 16);
      limit = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 64);
      limit[CW-1:ITER_BITS] = (CW-ITER_BITS)'($urandom);   // ignored upper bits
      if ($urandom_range(7) == 0) begin
        x0 = $urandom;
        y0 = $urandom;
        dx = $urandom;
        dy = $urandom;
      end else begin
        x0 = $urandom_range(0, 805306368) - 671088640;   // -2.5 .. 0.5
        y0 = $urandom_range(0, 805306368) - 402653184;   // -1.5 .. 1.5
        dx = $urandom_range(0, ($urandom_range(3) == 0) ? (1 << 20) : (1 << 16));
        dy = $urandom_range(0, ($urandom_range(3) == 0) ? (1 << 20) : (1 << 16));
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
      end
      write_view(x0, dx, y0, dy, limit);
      repeat (20) send_pixel(coord_t'($urandom), coord_t'($urandom));
      drain_pixels();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_view();
    test_zero_limit();
    test_unmapped_and_min_limit();
    test_extreme_views();
    test_random_views();
    if (faults == 0) begin
      $display("mandelbrot_escape_pixel_test: done, clean");
    end else begin
      $display("mandelbrot_escape_pixel_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mep_pkg.sv
design/mep_gray_div.sv
design/mandelbrot_escape_pixel.sv
tb/sv/mandelbrot_escape_pixel_test.sv
